// ===== design/psa_pkg.sv =====
`timescale 1ns / 1ps

package psa_pkg;

   localparam int PORT_W   = 16;
   localparam int OWNER_W  = 22;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REL_PORT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REL_OWNER = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;       // capture request word, clear scan, preset result
      logic inc_idx;     // advance the scan index
      logic alloc_take;  // claim the slot under the scan index
      logic alloc_full;  // no free slot was found
      logic port_rel;    // release by port, resolved without a scan
      logic own_free;    // free the slot in the compare stage
      logic own_miss;    // owner matched nothing
      logic ld_rsp;      // move the result into the output register
   } psa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;   // slot under the scan index is unused
      logic idx_last;    // scan index is at the last slot
      logic own_hit;     // compare stage holds a used slot of the owner
      logic cmp_last;    // compare stage holds the last slot
      logic rsp_free;    // output register can take a new word
   } psa_sts_type;

endpackage

// ===== design/psa_req_bus.sv =====
`timescale 1ns / 1ps

interface psa_req_bus import psa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [PORT_W-1:0]  port_number;
   logic [OWNER_W-1:0] owner_id;

   modport source (output valid, output cmd, output port_number, output owner_id,
                   input ready);
   modport sink   (input valid, input cmd, input port_number, input owner_id,
                   output ready);
endinterface

// ===== design/psa_rsp_bus.sv =====
`timescale 1ns / 1ps

interface psa_rsp_bus import psa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PORT_W-1:0]   granted_port;

   modport source (output valid, output status, output granted_port, input ready);
   modport sink   (input valid, input status, input granted_port, output ready);
endinterface

// ===== design/psa_datapath.sv =====
`timescale 1ns / 1ps

module psa_datapath import psa_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [PORT_W-1:0]   csr_wr_data,
   input  logic [PORT_W-1:0]   req_port_number,
   input  logic [OWNER_W-1:0]  req_owner_id,
   input  psa_cmd_type         cmd,
   output psa_sts_type         sts,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PORT_W-1:0]   rsp_granted_port
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(SLOTS - 1);
   localparam logic [PORT_W-1:0] SLOTS_PORT = PORT_W'(SLOTS);

   logic [PORT_W-1:0]   base_ff;
   logic [PORT_W-1:0]   port_ff;
   logic [OWNER_W-1:0]  owner_ff;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [OWNER_W-1:0]  rd_ff;
   logic [SLOTS-1:0]    used_ff, used_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [PORT_W-1:0]   res_port_ff, res_port_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PORT_W-1:0]   rsp_port_ff;
   logic [OWNER_W-1:0]  owner_mem [SLOTS];

   logic [PORT_W-1:0]   port_off;
   logic                port_hit;

   // Slot of a port is its distance from the base, modulo the port space.
   assign port_off = port_ff - base_ff;
   assign port_hit = (port_off < SLOTS_PORT);

   assign sts.slot_free = !used_ff[idx_ff];
   assign sts.idx_last  = (idx_ff == IDX_LAST);
   assign sts.own_hit   = cmp_vld_ff && used_ff[cmp_idx_ff] && (rd_ff == owner_ff);
   assign sts.cmp_last  = cmp_vld_ff && (cmp_idx_ff == IDX_LAST);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      idx_in        = idx_ff;
      cmp_vld_in    = cmp_vld_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_port_in   = res_port_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (cmd.start) begin
         idx_in        = '0;
         cmp_vld_in    = 1'b0;
         res_status_in = ST_OK;
         res_port_in   = '0;
      end
      if (cmd.inc_idx) begin
         idx_in     = idx_ff + 1'b1;
         cmp_vld_in = 1'b1;
      end
      if (cmd.alloc_take) begin
         used_in[idx_ff] = 1'b1;
         res_port_in     = base_ff + PORT_W'(idx_ff);
      end
      if (cmd.alloc_full) begin
         res_status_in = ST_FULL;
      end
      if (cmd.port_rel) begin
         if (port_hit) begin
            used_in[port_off[IDX_W-1:0]] = 1'b0;
         end else begin
            res_status_in = ST_NOMATCH;
         end
      end
      if (cmd.own_free) begin
         used_in[cmp_idx_ff] = 1'b0;
      end
      if (cmd.own_miss) begin
         res_status_in = ST_NOMATCH;
      end
      if (cmd.ld_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         used_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         used_ff      <= used_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         port_ff  <= req_port_number;
         owner_ff <= req_owner_id;
      end
      if (cmd.ld_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_port_ff   <= res_port_ff;
      end
      idx_ff        <= idx_in;
      cmp_idx_ff    <= idx_ff;
      res_status_ff <= res_status_in;
      res_port_ff   <= res_port_in;
   end

   // Owner table: one write port for allocation, one registered read for the scan.
   always_ff @(posedge clock) begin
      if (cmd.alloc_take) begin
         owner_mem[idx_ff] <= owner_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= owner_mem[idx_ff];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_port = rsp_port_ff;

endmodule

// ===== design/psa_controller.sv =====
`timescale 1ns / 1ps

module psa_controller import psa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CMD_W-1:0] req_cmd,
   input  psa_sts_type      sts,
   output psa_cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ALLOC = 5'b00010,
      S_PORT  = 5'b00100,
      S_OWNER = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               case (req_cmd)
                  CMD_ALLOC:     state_in = S_ALLOC;
                  CMD_REL_PORT:  state_in = S_PORT;
                  CMD_REL_OWNER: state_in = S_OWNER;
                  default:       state_in = S_DONE;
               endcase
            end
         end
         S_ALLOC: begin
            if (sts.slot_free) begin
               cmd.alloc_take = 1'b1;
               state_in       = S_DONE;
            end else if (sts.idx_last) begin
               cmd.alloc_full = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.inc_idx = 1'b1;
            end
         end
         S_PORT: begin
            cmd.port_rel = 1'b1;
            state_in     = S_DONE;
         end
         S_OWNER: begin
            // The read issued here is compared in the next cycle.
            if (sts.own_hit) begin
               cmd.own_free = 1'b1;
               state_in     = S_DONE;
            end else if (sts.cmp_last) begin
               cmd.own_miss = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.inc_idx = !sts.idx_last || !sts.cmp_last;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.ld_rsp = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/port_slot_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Signals
// req_bus   in         valid, ready, cmd, port_number, owner_id
// rsp_bus   out        valid, ready, status, granted_port
// csr       in         csr_wr_en, csr_wr_data (base port)
//
// Allocate scans the used flags one slot per cycle.
// Release by owner reads the owner table one slot per cycle through its registered
// read port. Release by port needs no scan; an unknown command goes straight to the final state.
// One word is in work at a time; a new request is taken while a result waits.
// Reset is synchronous and frees every slot; base port returns to zero.
// A stalled response holds the block in its final state until the output frees up.

module port_slot_allocator import psa_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   psa_req_bus.sink          req_bus,
   psa_rsp_bus.source        rsp_bus,
   input  logic              csr_wr_en,
   input  logic [PORT_W-1:0] csr_wr_data
);

   psa_cmd_type cmd;
   psa_sts_type sts;

   psa_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_cmd   (req_bus.cmd),
      .sts       (sts),
      .cmd       (cmd)
   );

   psa_datapath #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_port_number  (req_bus.port_number),
      .req_owner_id     (req_bus.owner_id),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_status       (rsp_bus.status),
      .rsp_granted_port (rsp_bus.granted_port)
   );

endmodule

// ===== design/psa_checker.sv =====
`timescale 1ns / 1ps

module psa_checker import psa_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [PORT_W-1:0]   rsp_granted_port
);

   // A stalled response word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_granted_port))
      else $error("response word changed while stalled");

   // Only a successful allocation carries a port.
   a_no_port_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_granted_port == '0)
      else $error("failed command returned a port");

   // The output register loads only from the final state, so a request never answers at once.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after a request");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind port_slot_allocator psa_checker u_psa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_granted_port (rsp_bus.granted_port)
);
